// ===== design/vn_pkg.sv =====
// Shared constants and types for the vector normalisation pipeline.
`default_nettype none
package vn_pkg;

  // Fraction bits of the normalised components.
  localparam int FRAC_OUT = 14;
  // Quotient bits: the magnitude never exceeds the length, so the result is at most 2^14.
  localparam int QW = FRAC_OUT + 1;
  // Width of every result field except the flag.
  localparam int OUT_W = 16;
  // Width of the epsilon register.
  localparam int EPS_W = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;
  // Number of vector lanes.
  localparam int LANES = 3;

  // Data that travels beside the quotient lanes through the divider cells.
  typedef struct packed {
    logic             three;
    logic             short_len;
    logic [OUT_W-1:0] len_sat;
    logic [LANES-1:0] neg;
  } div_side_t;

endpackage
`default_nettype wire

// ===== design/vn_sqrt_cell.sv =====
// One cell of the square root chain: settles one bit of the root per cycle while enabled.
`default_nettype none
module vn_sqrt_cell #(
  parameter int W      = 16,
  parameter int SIDE_W = 52
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [2*W-1:0]    in_rad,
  input  wire logic [W+1:0]      in_rem,
  input  wire logic [W-1:0]      in_root,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [2*W-1:0]         out_rad,
  output logic [W+1:0]           out_rem,
  output logic [W-1:0]           out_root,
  output logic [SIDE_W-1:0]      out_side
);

  logic              valid_r;
  logic [2*W-1:0]    rad_r, rad_nxt;
  logic [W+1:0]      rem_r, rem_nxt;
  logic [W-1:0]      root_r, root_nxt;
  logic [SIDE_W-1:0] side_r;
  logic [W+3:0]      shifted;
  logic [W+3:0]      trial;
  logic [W+3:0]      diff;
  logic              fits;

  // Bring down the next two radicand bits and try the digit one.
  always_comb begin
    shifted  = {in_rem, in_rad[2*W-1 -: 2]};
    trial    = {2'b00, in_root, 2'b01};
    diff     = shifted - trial;
    fits     = (shifted >= trial);
    rem_nxt  = fits ? diff[W+1:0] : shifted[W+1:0];
    root_nxt = {in_root[W-2:0], fits};
    rad_nxt  = {in_rad[2*W-3:0], 2'b00};
  end

  // Valid flag is control state; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rad   = rad_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_side  = side_r;

endmodule
`default_nettype wire

// ===== design/vn_div_cell.sv =====
// One cell of the divider chain: one quotient bit per lane per cycle while enabled.
`default_nettype none
module vn_div_cell #(
  parameter int W = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   en,
  input  wire logic                                   in_valid,
  input  wire logic [W-1:0]                           in_div,
  input  wire logic [vn_pkg::LANES-1:0][W-1:0]        in_rem,
  input  wire logic [vn_pkg::LANES-1:0][vn_pkg::QW-1:0] in_low,
  input  wire logic [vn_pkg::LANES-1:0][vn_pkg::QW-1:0] in_q,
  input  wire vn_pkg::div_side_t                      in_side,
  output logic                                        out_valid,
  output logic [W-1:0]                                out_div,
  output logic [vn_pkg::LANES-1:0][W-1:0]             out_rem,
  output logic [vn_pkg::LANES-1:0][vn_pkg::QW-1:0]    out_low,
  output logic [vn_pkg::LANES-1:0][vn_pkg::QW-1:0]    out_q,
  output vn_pkg::div_side_t                           out_side
);
  import vn_pkg::*;

  logic                       valid_r;
  logic [W-1:0]               div_r;
  logic [LANES-1:0][W-1:0]    rem_r, rem_nxt;
  logic [LANES-1:0][QW-1:0]   low_r, low_nxt;
  logic [LANES-1:0][QW-1:0]   q_r, q_nxt;
  div_side_t                  side_r;
  logic [LANES-1:0][W:0]      shifted;
  logic [LANES-1:0][W:0]      diff;
  logic [LANES-1:0]           fits;

  // Restoring division step in each lane against the shared length.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      shifted[i] = {in_rem[i], in_low[i][QW-1]};
      diff[i]    = shifted[i] - {1'b0, in_div};
      fits[i]    = (shifted[i] >= {1'b0, in_div});
      rem_nxt[i] = fits[i] ? diff[i][W-1:0] : shifted[i][W-1:0];
      low_nxt[i] = {in_low[i][QW-2:0], 1'b0};
      q_nxt[i]   = {in_q[i][QW-2:0], fits[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r  <= in_div;
      rem_r  <= rem_nxt;
      low_r  <= low_nxt;
      q_r    <= q_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_div   = div_r;
  assign out_rem   = rem_r;
  assign out_low   = low_r;
  assign out_q     = q_r;
  assign out_side  = side_r;

endmodule
`default_nettype wire

// ===== design/vector_normalize_2d_3d.sv =====
// A vector passes the sign stage, squares, sum, square root chain, length stage, divider chain and output register.
// Throughput: one vector per cycle while the result is not stalled; the square root chain has one cell per root bit and
// the divider chain one cell per quotient bit, each cell taking a new vector every cycle.
// A stalled result holds the whole pipeline still; ready follows the output register.
// Reset (synchronous, active low) empties the pipeline and sets the epsilon to one.
`default_nettype none
module vector_normalize_2d_3d #(
  parameter int COMP_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // Input: tdata holds comp_x, comp_y, comp_z from the lowest bit up; tuser holds dims_three.
  input  wire logic                                    in_tvalid,
  output logic                                         in_tready,
  input  wire logic [((3*COMP_WIDTH+7)/8)*8-1:0]       in_tdata,
  input  wire logic                                    in_tuser,
  // Result: tdata holds unit_x, unit_y, unit_z, vec_length; tuser holds too_short.
  output logic                                         out_tvalid,
  input  wire logic                                    out_tready,
  output logic [4*vn_pkg::OUT_W-1:0]                   out_tdata,
  output logic                                         out_tuser,
  // Configuration: length_epsilon.
  input  wire logic                                    cfg_wr_en,
  input  wire logic [vn_pkg::EPS_W-1:0]                cfg_wr_data
);
  import vn_pkg::*;

  localparam int W      = COMP_WIDTH;
  localparam int SIDE_W = 3*W + 4;
  localparam int CW     = (W > EPS_W) ? W : EPS_W;

  logic adv;
  logic [EPS_W-1:0] eps_r;

  // Pipeline advances whenever the output register is free or being emptied.
  logic out_valid_r;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // Epsilon register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_wr_en) begin
      eps_r <= cfg_wr_data;
    end
  end

  // Stage 0: sign and magnitude of each component; z dropped in two-component mode.
  logic                      v0_r, v1_r, v2_r;
  logic [LANES-1:0][W-1:0]   mag0_r, mag0_nxt, mag1_r, mag2_r;
  logic [LANES-1:0]          neg0_r, neg0_nxt, neg1_r, neg2_r;
  logic                      three0_r, three1_r, three2_r;
  logic [LANES-1:0][2*W-1:0] sq1_r;
  logic [2*W-1:0]            sum2_r;
  logic [W-1:0]              comp;

  always_comb begin
    comp = '0;
    for (int i = 0; i < LANES; i++) begin
      comp        = in_tdata[i*W +: W];
      neg0_nxt[i] = comp[W-1];
      mag0_nxt[i] = comp[W-1] ? (~comp + W'(1)) : comp;
    end
    if (!in_tuser) begin
      neg0_nxt[2] = 1'b0;
      mag0_nxt[2] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // Stages 1 and 2: squares, then their sum.
  always_ff @(posedge clk) begin
    if (adv) begin
      mag0_r   <= mag0_nxt;
      neg0_r   <= neg0_nxt;
      three0_r <= in_tuser;
      for (int i = 0; i < LANES; i++) begin
        sq1_r[i] <= mag0_r[i] * mag0_r[i];
      end
      mag1_r   <= mag0_r;
      neg1_r   <= neg0_r;
      three1_r <= three0_r;
      sum2_r   <= sq1_r[0] + sq1_r[1] + sq1_r[2];
      mag2_r   <= mag1_r;
      neg2_r   <= neg1_r;
      three2_r <= three1_r;
    end
  end

  // Square root chain, one cell per root bit.
  logic                 sq_v    [0:W];
  logic [2*W-1:0]       sq_rad  [0:W];
  logic [W+1:0]         sq_rem  [0:W];
  logic [W-1:0]         sq_root [0:W];
  logic [SIDE_W-1:0]    sq_side [0:W];

  assign sq_v[0]    = v2_r;
  assign sq_rad[0]  = sum2_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = {three2_r, neg2_r, mag2_r};

  for (genvar g = 0; g < W; g++) begin : g_sqrt
    vn_sqrt_cell #(.W(W), .SIDE_W(SIDE_W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_valid (sq_v[g]),
      .in_rad   (sq_rad[g]),
      .in_rem   (sq_rem[g]),
      .in_root  (sq_root[g]),
      .in_side  (sq_side[g]),
      .out_valid(sq_v[g+1]),
      .out_rad  (sq_rad[g+1]),
      .out_rem  (sq_rem[g+1]),
      .out_root (sq_root[g+1]),
      .out_side (sq_side[g+1])
    );
  end

  // Length stage: epsilon test, saturated length and divider set-up.
  logic [W-1:0]              len;
  logic [CW-1:0]             len_ext;
  logic [LANES-1:0][W-1:0]   smag;
  logic [LANES-1:0]          sneg;
  logic                      sthree;
  logic                      pv_r;
  logic [W-1:0]              plen_r;
  logic [LANES-1:0][W-1:0]   prem_r, prem_nxt;
  logic [LANES-1:0][QW-1:0]  plow_r, plow_nxt;
  div_side_t                 pside_r, pside_nxt;

  always_comb begin
    len     = sq_root[W];
    len_ext = CW'(len);
    {sthree, sneg, smag} = sq_side[W];
    pside_nxt.three     = sthree;
    pside_nxt.neg       = sneg;
    pside_nxt.short_len = (len == '0) || (len_ext < CW'(eps_r));
    pside_nxt.len_sat   = (len_ext > CW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : len_ext[OUT_W-1:0];
    for (int i = 0; i < LANES; i++) begin
      prem_nxt[i] = smag[i] >> 1;
      plow_nxt[i] = {smag[i][0], {(QW-1){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (adv) begin
      pv_r <= sq_v[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      plen_r  <= len;
      prem_r  <= prem_nxt;
      plow_r  <= plow_nxt;
      pside_r <= pside_nxt;
    end
  end

  // Divider chain, one cell per quotient bit.
  logic                      dv_v    [0:QW];
  logic [W-1:0]              dv_div  [0:QW];
  logic [LANES-1:0][W-1:0]   dv_rem  [0:QW];
  logic [LANES-1:0][QW-1:0]  dv_low  [0:QW];
  logic [LANES-1:0][QW-1:0]  dv_q    [0:QW];
  div_side_t                 dv_side [0:QW];

  assign dv_v[0]    = pv_r;
  assign dv_div[0]  = plen_r;
  assign dv_rem[0]  = prem_r;
  assign dv_low[0]  = plow_r;
  assign dv_q[0]    = '0;
  assign dv_side[0] = pside_r;

  for (genvar g = 0; g < QW; g++) begin : g_div
    vn_div_cell #(.W(W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_valid (dv_v[g]),
      .in_div   (dv_div[g]),
      .in_rem   (dv_rem[g]),
      .in_low   (dv_low[g]),
      .in_q     (dv_q[g]),
      .in_side  (dv_side[g]),
      .out_valid(dv_v[g+1]),
      .out_div  (dv_div[g+1]),
      .out_rem  (dv_rem[g+1]),
      .out_low  (dv_low[g+1]),
      .out_q    (dv_q[g+1]),
      .out_side (dv_side[g+1])
    );
  end

  // Output register: sign restored, zero vector for short lengths and the unused z.
  logic [LANES-1:0][OUT_W-1:0] unit_nxt, unit_r;
  logic [OUT_W-1:0]            qext;
  logic [OUT_W-1:0]            len_r;
  logic                        short_r;
  div_side_t                   fside;

  always_comb begin
    fside = dv_side[QW];
    qext  = '0;
    for (int i = 0; i < LANES; i++) begin
      qext        = OUT_W'(dv_q[QW][i]);
      unit_nxt[i] = fside.neg[i] ? (~qext + OUT_W'(1)) : qext;
      if (fside.short_len) begin
        unit_nxt[i] = '0;
      end
    end
    if (!fside.three) begin
      unit_nxt[2] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unit_r  <= unit_nxt;
      len_r   <= fside.len_sat;
      short_r <= fside.short_len;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {len_r, unit_r[2], unit_r[1], unit_r[0]};
  assign out_tuser  = short_r;

  // A flagged result carries the zero vector.
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && short_r |-> unit_r[0] == '0 && unit_r[1] == '0 && unit_r[2] == '0)
    else $error("short vector with non-zero components");

  // A normalised result never has zero length.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !short_r |-> len_r != '0)
    else $error("normalised result with zero length");

  // Normalised components stay within plus or minus one.
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !short_r |->
      ($signed(unit_r[0]) <= 16384 && $signed(unit_r[0]) >= -16384) &&
      ($signed(unit_r[1]) <= 16384 && $signed(unit_r[1]) >= -16384) &&
      ($signed(unit_r[2]) <= 16384 && $signed(unit_r[2]) >= -16384))
    else $error("normalised component out of range");

endmodule
`default_nettype wire

// ===== sim/vector_normalize_2d_3d_tb.sv =====
// Self-checking testbench for the 2-D/3-D fixed-point vector normalisation pipeline.
`timescale 1ns / 100ps
`default_nettype none
module vector_normalize_2d_3d_tb;
  import vn_pkg::*;

  localparam int CW = 16;
  localparam int IN_W = ((3*CW+7)/8)*8;
  localparam int LATENCY = CW + 20;

  typedef struct packed {
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
    logic [15:0]        len;
    logic               short_flag;
  } norm_result_t;

  typedef struct {
    logic        three;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        known;
    norm_result_t res;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [4*OUT_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_wr_en = 1'b0;
  logic [EPS_W-1:0] cfg_wr_data = '0;

  logic [15:0] epsilon;
  norm_result_t pending_results[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int beats_checked = 0;
  int vectors_sent = 0;
  int short_seen = 0;

  vector_normalize_2d_3d #(.COMP_WIDTH(CW)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Integer square root, floor, by the bitwise method.
  function automatic logic [31:0] floor_root(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem = n;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[31:0];
  endfunction

  // Scales one component to Q1.14 by the length, truncating toward zero.
  function automatic logic [15:0] unit_component(input logic [15:0] c, input logic [31:0] len);
    logic [15:0] mag16;
    logic [63:0] mag;
    logic [63:0] q;
    mag16 = c[15] ? 16'(~c + 16'd1) : c;
    mag = {48'd0, mag16};
    q = (mag << FRAC_OUT) / len;
    if (c[15]) q = -q;
    return q[15:0];
  endfunction

  function automatic norm_result_t normalise(input logic three, input logic [15:0] x,
                                             input logic [15:0] y, input logic [15:0] z);
    norm_result_t r;
    logic signed [63:0] sx, sy, sz;
    logic [63:0] sum;
    logic [31:0] len;
    sx = $signed(x);
    sy = $signed(y);
    sz = three ? $signed(z) : 64'sd0;
    sum = sx*sx + sy*sy + sz*sz;
    len = floor_root(sum);
    r.len = (len > 32'hFFFF) ? 16'hFFFF : len[15:0];
    if (len == 0 || len < {16'd0, epsilon}) begin
      r.ux = 0; r.uy = 0; r.uz = 0; r.short_flag = 1'b1;
    end else begin
      r.ux = unit_component(x, len);
      r.uy = unit_component(y, len);
      r.uz = three ? unit_component(z, len) : 16'd0;
      r.short_flag = 1'b0;
    end
    return r;
  endfunction

  // Sends one vector beat, optionally idling first, and records its expected result.
  task automatic send_vector(input logic three, input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input logic known, input norm_result_t res);
    norm_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    predicted = normalise(three, x, y, z);
    if (known && predicted != res)
      $display("Table row disagrees with prediction: x=%h y=%h z=%h", x, y, z);
    pending_results.push_back(known ? res : predicted);
    in_tvalid <= 1'b1;
    in_tuser <= three;
    in_tdata <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    vectors_sent++;
  endtask

  task automatic drop_valid();
    in_tvalid <= 1'b0;
  endtask

  // Waits for every expected beat, then lets the pipeline drain before a register write.
  task automatic drain_and_write(input logic [15:0] value);
    drop_valid();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    epsilon = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Receiver: random stalls and a check of each accepted beat.
  always @(posedge clk) begin
    norm_result_t got;
    norm_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.ux = out_tdata[15:0];
        got.uy = out_tdata[31:16];
        got.uz = out_tdata[47:32];
        got.len = out_tdata[63:48];
        got.short_flag = out_tuser;
        beats_checked++;
        if (got.short_flag) short_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result beat: %p", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [15:0] random_comp();
    case ($urandom_range(5))
      0: return 16'h8000 | 16'($urandom_range(3));
      1: return 16'h7FFF - 16'($urandom_range(3));
      2: return 16'($signed(16'($urandom_range(40))) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int count);
    logic three;
    logic [15:0] x, y, z;
    for (int i = 0; i < count; i++) begin
      three = $urandom_range(1);
      x = random_comp();
      y = random_comp();
      z = random_comp();
      send_vector(three, x, y, z, 1'b0, '0);
    end
  endtask

  vec_row_t directed_rows[$];

  initial begin
    vec_row_t row;
    epsilon = EPS_RESET;
    // Rows with a result typed in are the obvious ones; the rest use the prediction.
    directed_rows = '{
      '{1'b0, 16'h0000, 16'h0000, 16'h1234, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1}},
      '{1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1}},
      '{1'b0, 16'h1000, 16'h0000, 16'h7FFF, 1'b1,
        '{16'sd16384, 16'd0, 16'd0, 16'h1000, 1'b0}},
      '{1'b1, 16'h0000, 16'hF000, 16'h0000, 1'b1,
        '{16'd0, -16'sd16384, 16'd0, 16'h1000, 1'b0}},
      '{1'b1, 16'h0000, 16'h0000, 16'h8000, 1'b1,
        '{16'd0, 16'd0, -16'sd16384, 16'h8000, 1'b0}},
      '{1'b0, 16'h0001, 16'h0000, 16'h0000, 1'b1,
        '{16'sd16384, 16'd0, 16'd0, 16'h0001, 1'b0}},
      '{1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0},
      '{1'b1, 16'h8000, 16'h8000, 16'h8000, 1'b0, '0},
      '{1'b0, 16'h8000, 16'h7FFF, 16'h5555, 1'b0, '0},
      '{1'b1, 16'h0003, 16'hFFFC, 16'h000C, 1'b0, '0},
      '{1'b0, 16'hAAAA, 16'h5555, 16'hFFFF, 1'b0, '0},
      '{1'b1, 16'h5555, 16'hAAAA, 16'hFFFF, 1'b0, '0},
      '{1'b1, 16'hFFFF, 16'h0001, 16'h0001, 1'b0, '0}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table at the reset epsilon.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_vector(row.three, row.x, row.y, row.z, row.known, row.res);
    end

    // Zero epsilon: only a zero length is short.
    drain_and_write(16'd0);
    send_vector(1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1});
    send_vector(1'b1, 16'h0000, 16'h0000, 16'h0001, 1'b1,
                '{16'd0, 16'd0, 16'sd16384, 16'd1, 1'b0});

    // Largest epsilon: every length is short.
    drain_and_write(16'hFFFF);
    send_vector(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0);
    send_vector(1'b0, 16'h1000, 16'h0000, 16'h0000, 1'b1,
                '{16'd0, 16'd0, 16'd0, 16'h1000, 1'b1});
    send_vector(1'b1, 16'h8000, 16'h8000, 16'h8000, 1'b0, '0);

    // Random phases: sender idles little, then receiver little, then neither.
    drain_and_write(16'h1000);
    send_idle_pct = 7; recv_idle_pct = 66;
    random_phase(400);
    drain_and_write(16'($urandom));
    send_idle_pct = 66; recv_idle_pct = 7;
    random_phase(400);
    drain_and_write(16'd0);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(200);
    drain_and_write(16'd300);
    random_phase(200);

    drop_valid();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("Sent %0d vectors over seven epsilon settings; %0d result beats checked, %0d short.",
             vectors_sent, beats_checked, short_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("Timed out");
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
